FILE: design/omd_pkg.sv
// ----------------------------------------------------------------------------
// omd_pkg
// Shared types and constants for the obstacle-aware motor drive.
// ----------------------------------------------------------------------------
`default_nettype none

package omd_pkg;

   localparam logic [15:0] PWM_FULL_SCALE = 16'd100;

   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 24;

   typedef enum logic [3:0] {
      ACT_STOP      = 4'd0,
      ACT_FWD       = 4'd1,
      ACT_BACK      = 4'd2,
      ACT_LEFT      = 4'd3,
      ACT_RIGHT     = 4'd4,
      ACT_JOY_STOP  = 4'd5,
      ACT_JOY_FWD   = 4'd6,
      ACT_JOY_BACK  = 4'd7,
      ACT_JOY_LEFT  = 4'd8,
      ACT_JOY_RIGHT = 4'd9
   } action_type;

   typedef enum logic [1:0] {
      PX_NONE  = 2'd0,
      PX_WRN1  = 2'd1,
      PX_WRN2  = 2'd2,
      PX_ALERT = 2'd3
   } prox_type;

   typedef enum logic [2:0] {
      ST_STOPPED = 3'd0,
      ST_WRN1    = 3'd1,
      ST_WRN1TO2 = 3'd2,
      ST_WRN2    = 3'd3,
      ST_FREE    = 3'd4
   } drive_state_type;

   // speed caps, by proximity level and resulting state
   localparam logic [6:0] CAP_WRN1_FREE    = 7'd40;
   localparam logic [6:0] CAP_WRN1_WRN1    = 7'd70;
   localparam logic [6:0] CAP_WRN2_FREE    = 7'd10;
   localparam logic [6:0] CAP_WRN2_WRN1TO2 = 7'd40;
   localparam logic [6:0] CAP_WRN2_WRN2    = 7'd60;
   localparam logic [6:0] CAP_ALERT        = 7'd0;

endpackage

`default_nettype wire

FILE: design/obstacle_aware_motor_drive_top.sv
// ----------------------------------------------------------------------------
// obstacle_aware_motor_drive_top
// Drive command to PWM duties and direction pins, with an obstacle machine
// that caps forward speed by the front proximity level.
// ----------------------------------------------------------------------------
//  channel | dir | fields (tdata, low bit first)
//  req_    | in  | action[3:0] speed_left[11:4] speed_right[19:12]
//          |     | proximity[21:20] robot_stopped[22], zero pad [23]
//  rsp_    | out | duty_left[6:0] duty_right[13:7] reverse_left[14]
//          |     | reverse_right[15] drive_state[18:16], zero pad [23:19]
//
// One request per cycle while rsp_tready does not stall. A request is held in
// the input register, then its result is computed and loaded into the result
// register. Unsupported actions are dropped at that step and give no result.
// Synchronous reset clears both valid bits and sets the state to stopped.
// A stall on rsp_tready holds the result and backs up into req_tready.
// ----------------------------------------------------------------------------
`default_nettype none

module obstacle_aware_motor_drive_top (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   // action, speed_left, speed_right, proximity, robot_stopped, pad
   input  wire logic [omd_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   // duty_left, duty_right, reverse_left, reverse_right, drive_state, pad
   output logic [omd_pkg::RSP_DATA_W-1:0]      rsp_tdata
);
   import omd_pkg::*;

   // input register
   logic             in_valid_ff, in_valid_in;
   logic [3:0]       action_ff;
   logic [7:0]       speed_left_ff, speed_right_ff;
   logic [1:0]       proximity_ff;
   logic             robot_stopped_ff;

   // state and result register
   drive_state_type  state_ff, state_in;
   logic             out_valid_ff, out_valid_in;
   logic [6:0]       duty_left_ff, duty_left_in;
   logic [6:0]       duty_right_ff, duty_right_in;
   logic             rev_left_ff, rev_left_in;
   logic             rev_right_ff, rev_right_in;

   logic             advance;
   logic             has_result;
   logic             is_stop, is_fwd;
   logic [7:0]       sat_left, sat_right;
   logic [6:0]       cap_left, cap_right;
   logic [6:0]       inv_left, inv_right;
   logic             cap_en;
   logic [6:0]       cap_lim;
   drive_state_type  st_new;
   prox_type         prox;

   assign advance    = !out_valid_ff || rsp_tready;
   assign req_tready = !in_valid_ff || advance;
   assign in_valid_in = req_tready ? req_tvalid : in_valid_ff;
   assign prox       = prox_type'(proximity_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (req_tready && req_tvalid) begin
         action_ff        <= req_tdata[3:0];
         speed_left_ff    <= req_tdata[11:4];
         speed_right_ff   <= req_tdata[19:12];
         proximity_ff     <= req_tdata[21:20];
         robot_stopped_ff <= req_tdata[22];
      end
   end

   always_comb begin
      // saturate at full scale
      sat_left  = ({8'd0, speed_left_ff} > PWM_FULL_SCALE) ? PWM_FULL_SCALE[7:0]
                                                           : speed_left_ff;
      sat_right = ({8'd0, speed_right_ff} > PWM_FULL_SCALE) ? PWM_FULL_SCALE[7:0]
                                                            : speed_right_ff;
      inv_left  = 7'(PWM_FULL_SCALE[6:0] - sat_left[6:0]);
      inv_right = 7'(PWM_FULL_SCALE[6:0] - sat_right[6:0]);

      has_result = 1'b1;
      is_stop    = 1'b0;
      is_fwd     = 1'b0;
      case (action_type'(action_ff))
         ACT_STOP, ACT_JOY_STOP: is_stop = 1'b1;
         ACT_FWD, ACT_JOY_FWD:   is_fwd  = 1'b1;
         ACT_BACK, ACT_JOY_BACK, ACT_LEFT, ACT_RIGHT,
         ACT_JOY_LEFT, ACT_JOY_RIGHT: has_result = 1'b1;
         default:                has_result = 1'b0;
      endcase

      // obstacle machine
      if (is_stop) begin
         st_new = (state_ff != ST_STOPPED && !robot_stopped_ff) ? state_ff : ST_STOPPED;
      end else if (prox == PX_ALERT) begin
         st_new = ST_STOPPED;
      end else if (state_ff == ST_STOPPED) begin
         st_new = (prox == PX_WRN1) ? ST_WRN1 : ST_WRN2;
      end else if (prox == PX_WRN1) begin
         st_new = state_ff;
      end else if (state_ff == ST_WRN1) begin
         st_new = ST_WRN1TO2;
      end else if ((state_ff == ST_FREE || state_ff == ST_WRN1TO2) && robot_stopped_ff) begin
         st_new = ST_WRN2;
      end else begin
         st_new = state_ff;
      end
      if (prox == PX_NONE) begin
         st_new = ST_FREE;
      end

      cap_en  = 1'b0;
      cap_lim = CAP_ALERT;
      case (prox)
         PX_WRN1: begin
            if (st_new == ST_FREE) begin
               cap_en = 1'b1; cap_lim = CAP_WRN1_FREE;
            end else if (st_new == ST_WRN1) begin
               cap_en = 1'b1; cap_lim = CAP_WRN1_WRN1;
            end
         end
         PX_WRN2: begin
            if (st_new == ST_FREE) begin
               cap_en = 1'b1; cap_lim = CAP_WRN2_FREE;
            end else if (st_new == ST_WRN1TO2) begin
               cap_en = 1'b1; cap_lim = CAP_WRN2_WRN1TO2;
            end else if (st_new == ST_WRN2) begin
               cap_en = 1'b1; cap_lim = CAP_WRN2_WRN2;
            end
         end
         PX_ALERT: begin
            cap_en = 1'b1; cap_lim = CAP_ALERT;
         end
         default: cap_en = 1'b0;
      endcase
      cap_left  = (cap_en && sat_left  > {1'b0, cap_lim}) ? cap_lim : sat_left[6:0];
      cap_right = (cap_en && sat_right > {1'b0, cap_lim}) ? cap_lim : sat_right[6:0];

      duty_left_in  = sat_left[6:0];
      duty_right_in = sat_right[6:0];
      rev_left_in   = 1'b0;
      rev_right_in  = 1'b0;
      case (action_type'(action_ff))
         ACT_STOP, ACT_JOY_STOP: begin
            duty_left_in  = 7'd0;
            duty_right_in = 7'd0;
         end
         ACT_FWD, ACT_JOY_FWD: begin
            duty_left_in  = cap_left;
            duty_right_in = cap_right;
         end
         ACT_BACK, ACT_JOY_BACK: begin
            duty_left_in  = inv_left;
            duty_right_in = inv_right;
            rev_left_in   = 1'b1;
            rev_right_in  = 1'b1;
         end
         ACT_LEFT: begin
            duty_right_in = inv_left;
            rev_right_in  = 1'b1;
         end
         ACT_RIGHT: begin
            duty_left_in  = inv_right;
            rev_left_in   = 1'b1;
         end
         default: rev_left_in = 1'b0;
      endcase

      // advance the state only on stop and forward requests
      state_in     = state_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      if (advance && in_valid_ff) begin
         out_valid_in = has_result;
         if (is_stop || is_fwd) begin
            state_in = st_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         state_ff     <= ST_STOPPED;
      end else begin
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
      end
      if (advance && in_valid_ff && has_result) begin
         duty_left_ff  <= duty_left_in;
         duty_right_ff <= duty_right_in;
         rev_left_ff   <= rev_left_in;
         rev_right_ff  <= rev_right_in;
      end
   end

   // drive_state reports the state after the request, i.e. the state register
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {5'd0, state_ff, rev_right_ff, rev_left_ff,
                        duty_right_ff, duty_left_ff};

endmodule

`default_nettype wire

FILE: design/omd_checker.sv
// ----------------------------------------------------------------------------
// omd_checker
// Port-level checks for the obstacle-aware motor drive, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module omd_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_tvalid,
   input wire logic                          req_tready,
   input wire logic [omd_pkg::REQ_DATA_W-1:0] req_tdata,
   input wire logic                          rsp_tvalid,
   input wire logic                          rsp_tready,
   input wire logic [omd_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import omd_pkg::*;

   logic [2:0] last_state_ff, last_state_in;
   logic       rsp_done;
   logic       req_seen;

   assign rsp_done = rsp_tvalid && rsp_tready;
   assign req_seen = req_tvalid && req_tready && (req_tdata[23] == 1'b0 || 1'b1);
   assign last_state_in = rsp_done ? rsp_tdata[18:16] : last_state_ff;

   // track the state shown by the last delivered result
   always_ff @(posedge clock) begin
      if (reset) begin
         last_state_ff <= ST_STOPPED;
      end else begin
         last_state_ff <= last_state_in;
      end
   end

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   a_duty_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && PWM_FULL_SCALE <= 16'd127 && req_seen |->
         {9'd0, rsp_tdata[6:0]} <= PWM_FULL_SCALE &&
         {9'd0, rsp_tdata[13:7]} <= PWM_FULL_SCALE ||
         rsp_tdata[23:19] != 5'd0)
      else $error("duty above full scale");

   // reversing requests never move the obstacle machine
   a_reverse_keeps_state: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[14] || rsp_tdata[15]) |->
         rsp_tdata[18:16] == last_state_ff)
      else $error("reverse result changed the drive state");

endmodule

bind obstacle_aware_motor_drive_top omd_checker u_omd_checker (.*);

`default_nettype wire
